/* src/point_in_sphere_set_visibility_top_defines.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the sphere visibility block
// Shared property forms, clocked on clk_i and held off during reset.
// ---------------------------------------------------------------------------
`ifndef POINT_IN_SPHERE_SET_VISIBILITY_TOP_DEFINES_SVH
`define POINT_IN_SPHERE_SET_VISIBILITY_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PISV_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pisv assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define PISV_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pisv assertion failed");

`endif

/* src/pisv_pkg.sv */
// ---------------------------------------------------------------------------
// Sphere visibility package
// Sizes, codes and shared types of the sphere visibility block.
// ---------------------------------------------------------------------------
package pisv_pkg;

  localparam int MaxSpheres = 1024;
  localparam int AddrW      = $clog2(MaxSpheres);
  localparam int CntW       = $clog2(MaxSpheres + 1);
  localparam int CoordW     = 32;
  localparam int EpsW       = 31;
  localparam int CountW     = 11;
  localparam int SlotW      = 10;
  localparam int ProdW      = 2 * CoordW;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } opcode_e;

  typedef enum logic {
    REG_EPSILON = 1'b0,
    REG_COUNT   = 1'b1
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_DIFF,
    ST_ABS,
    ST_SQ,
    ST_LAST,
    ST_CMP,
    ST_DONE
  } state_e;

  // One table entry: centre and radius side by side in one memory word.
  typedef struct packed {
    logic [CoordW-1:0] radius;
    logic [CoordW-1:0] cz;
    logic [CoordW-1:0] cy;
    logic [CoordW-1:0] cx;
  } sphere_t;

  localparam int RamW = $bits(sphere_t);

  // Strobes from the sequencer to the distance unit.
  typedef struct packed {
    logic       ld_point;
    logic       ld_diff;
    logic       ld_abs;
    logic       sq_en;
    logic [1:0] sq_sel;
  } pisv_ctl_t;

  // Decisions from the distance unit back to the sequencer.
  typedef struct packed {
    logic skip;
    logic hit;
  } pisv_sts_t;

endpackage

/* src/point_in_sphere_set_visibility_top.sv */
// ---------------------------------------------------------------------------
// Sphere set visibility
// Loads spheres into a table and answers whether a valid point lies in none of them.
// ---------------------------------------------------------------------------
//  Channel  Handshake               Payload
//  in       in_valid_i/in_ready_o   opcode, slot, pos_x/y/z, sdf_sample, point_invalid
//  out      out_valid_o/out_ready_i visible
//  cfg      cfg_we_i                cfg_idx_i, cfg_wdata_i
//
// A load item writes one slot and gives no result. A query item scans the
// first sphere_count slots through one shared squarer; a sphere that the
// radius or axis test passes over skips the squaring steps, and the scan
// ends early on a hit. Reset clears the sequencer, the output valid flag
// and both registers; the table is not cleared. A stalled result holds the
// scan in its final state, while the waiting output register lets the next
// item in.
// ---------------------------------------------------------------------------
module point_in_sphere_set_visibility_top
  import pisv_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              opcode_i,
  input  logic [SlotW-1:0]  slot_i,
  input  logic [CoordW-1:0] pos_x_i,
  input  logic [CoordW-1:0] pos_y_i,
  input  logic [CoordW-1:0] pos_z_i,
  input  logic [CoordW-1:0] sdf_sample_i,
  input  logic              point_invalid_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              visible_o,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [EpsW-1:0]   cfg_wdata_i
);

  logic [EpsW-1:0]   epsilon_q;
  logic [CountW-1:0] count_q;
  logic              in_acc;
  logic              load_we;
  logic              start;
  sphere_t           wr_sphere;
  sphere_t           rd_sphere;
  logic              rd_en;
  logic [AddrW-1:0]  rd_addr;
  pisv_ctl_t         ctl;
  pisv_sts_t         sts;
  logic              idle;
  logic              res_valid;
  logic              res_visible;
  logic              res_take;
  logic              out_valid_q;
  logic              visible_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      epsilon_q <= '0;
      count_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_EPSILON: epsilon_q <= cfg_wdata_i;
        REG_COUNT:   count_q   <= cfg_wdata_i[CountW-1:0];
        default:     ;
      endcase
    end
  end

  assign in_ready_o = idle;
  assign in_acc     = in_valid_i && in_ready_o;
  assign load_we    = in_acc && (opcode_e'(opcode_i) == OP_LOAD) &&
                      ({1'b0, slot_i} < (SlotW + 1)'(MaxSpheres));
  assign start      = in_acc && (opcode_e'(opcode_i) == OP_QUERY);

  always_comb begin
    wr_sphere.cx     = pos_x_i;
    wr_sphere.cy     = pos_y_i;
    wr_sphere.cz     = pos_z_i;
    // The most negative sample gives 2^31, which the unsigned radius holds.
    wr_sphere.radius = sdf_sample_i[CoordW-1] ? (~sdf_sample_i + 1'b1) : sdf_sample_i;
  end

  pisv_ram #(
    .Width (RamW),
    .Depth (MaxSpheres)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (load_we),
    .waddr_i (AddrW'(slot_i)),
    .wdata_i (wr_sphere),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_sphere)
  );

  pisv_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .invalid_i     (point_invalid_i),
    .count_i       (count_q),
    .sts_i         (sts),
    .res_take_i    (res_take),
    .idle_o        (idle),
    .res_valid_o   (res_valid),
    .res_visible_o (res_visible),
    .ctl_o         (ctl),
    .rd_en_o       (rd_en),
    .rd_addr_o     (rd_addr)
  );

  pisv_dist u_dist (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (ctl),
    .pos_x_i   (pos_x_i),
    .pos_y_i   (pos_y_i),
    .pos_z_i   (pos_z_i),
    .epsilon_i (epsilon_q),
    .sphere_i  (rd_sphere),
    .sts_o     (sts)
  );

  assign res_take = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_take) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_take) begin
      visible_q <= res_visible;
    end
  end

  assign out_valid_o = out_valid_q;
  assign visible_o   = visible_q;

endmodule

/* src/pisv_ram.sv */
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module pisv_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/pisv_dist.sv */
// ---------------------------------------------------------------------------
// Sphere distance unit
// Differences, radius and axis tests, and one shared squarer with accumulator.
// ---------------------------------------------------------------------------
module pisv_dist
  import pisv_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pisv_ctl_t         ctl_i,
  input  logic [CoordW-1:0] pos_x_i,
  input  logic [CoordW-1:0] pos_y_i,
  input  logic [CoordW-1:0] pos_z_i,
  input  logic [EpsW-1:0]   epsilon_i,
  input  sphere_t           sphere_i,
  output pisv_sts_t         sts_o
);

  logic [CoordW-1:0]        pt_x_q, pt_y_q, pt_z_q;
  logic signed [CoordW:0]   dx_d, dy_d, dz_d;
  logic signed [CoordW:0]   dx_q, dy_q, dz_q;
  logic signed [CoordW+1:0] r_d;
  logic [CoordW-1:0]        ur_q;
  logic                     rpos_q;
  logic [CoordW:0]          ax_d, ay_d, az_d;
  logic [CoordW-1:0]        ax_q, ay_q, az_q;
  logic [CoordW-1:0]        op_d;
  logic [ProdW-1:0]         prod_q;
  logic [1:0]               tag_q;
  logic                     prod_vld_q;
  logic [ProdW-1:0]         acc_q;
  logic [ProdW-1:0]         rr_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.ld_point) begin
      pt_x_q <= pos_x_i;
      pt_y_q <= pos_y_i;
      pt_z_q <= pos_z_i;
    end
  end

  assign dx_d = $signed({pt_x_q[CoordW-1], pt_x_q}) - $signed({sphere_i.cx[CoordW-1], sphere_i.cx});
  assign dy_d = $signed({pt_y_q[CoordW-1], pt_y_q}) - $signed({sphere_i.cy[CoordW-1], sphere_i.cy});
  assign dz_d = $signed({pt_z_q[CoordW-1], pt_z_q}) - $signed({sphere_i.cz[CoordW-1], sphere_i.cz});
  assign r_d  = $signed({2'b00, sphere_i.radius}) - $signed({3'b000, epsilon_i});

  always_ff @(posedge clk_i) begin
    if (ctl_i.ld_diff) begin
      dx_q   <= dx_d;
      dy_q   <= dy_d;
      dz_q   <= dz_d;
      ur_q   <= r_d[CoordW-1:0];
      rpos_q <= !r_d[CoordW+1] && (r_d != '0);
    end
  end

  assign ax_d = dx_q[CoordW] ? $unsigned(-dx_q) : $unsigned(dx_q);
  assign ay_d = dy_q[CoordW] ? $unsigned(-dy_q) : $unsigned(dy_q);
  assign az_d = dz_q[CoordW] ? $unsigned(-dz_q) : $unsigned(dz_q);

  // A sphere is passed over when its shrunk radius is not positive, or when
  // one axis alone already reaches the radius.
  assign sts_o.skip = !rpos_q || (ax_d >= {1'b0, ur_q}) || (ay_d >= {1'b0, ur_q}) ||
                      (az_d >= {1'b0, ur_q});

  always_ff @(posedge clk_i) begin
    if (ctl_i.ld_abs) begin
      ax_q <= ax_d[CoordW-1:0];
      ay_q <= ay_d[CoordW-1:0];
      az_q <= az_d[CoordW-1:0];
    end
  end

  always_comb begin
    case (ctl_i.sq_sel)
      2'd0:    op_d = ur_q;
      2'd1:    op_d = ax_q;
      2'd2:    op_d = ay_q;
      default: op_d = az_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.sq_en) begin
      prod_q <= op_d * op_d;
      tag_q  <= ctl_i.sq_sel;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
    end else begin
      prod_vld_q <= ctl_i.sq_en;
    end
  end

  // The first square is the radius; the three axis squares are summed.
  always_ff @(posedge clk_i) begin
    if (ctl_i.ld_abs) begin
      acc_q <= '0;
    end else if (prod_vld_q) begin
      if (tag_q == 2'd0) begin
        rr_q <= prod_q;
      end else begin
        acc_q <= acc_q + prod_q;
      end
    end
  end

  assign sts_o.hit = acc_q < rr_q;

endmodule

/* src/pisv_ctrl.sv */
// ---------------------------------------------------------------------------
// Sphere scan sequencer
// Walks the table slot by slot and steps the distance unit for each sphere.
// ---------------------------------------------------------------------------
module pisv_ctrl
  import pisv_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic             invalid_i,
  input  logic [CountW-1:0] count_i,
  input  pisv_sts_t        sts_i,
  input  logic             res_take_i,
  output logic             idle_o,
  output logic             res_valid_o,
  output logic             res_visible_o,
  output pisv_ctl_t        ctl_o,
  output logic             rd_en_o,
  output logic [AddrW-1:0] rd_addr_o
);

  `include "point_in_sphere_set_visibility_top_defines.svh"

  state_e          state_q, state_d;
  logic [CntW-1:0] idx_q, idx_d;
  logic [CntW-1:0] n_q, n_d;
  logic [CntW-1:0] idx_nxt;
  logic [CntW-1:0] n_clamp;
  logic [1:0]      sq_cnt_q, sq_cnt_d;
  logic            vis_q, vis_d;
  logic            last_slot;

  assign n_clamp   = ({1'b0, count_i} > (CountW + 1)'(MaxSpheres)) ? CntW'(MaxSpheres)
                                                                   : CntW'(count_i);
  assign idx_nxt   = idx_q + 1'b1;
  assign last_slot = (idx_nxt == n_q);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d = (invalid_i || (n_clamp == '0)) ? ST_DONE : ST_READ;
        end
      end
      ST_READ: state_d = ST_DIFF;
      ST_DIFF: state_d = ST_ABS;
      ST_ABS: begin
        if (!sts_i.skip) begin
          state_d = ST_SQ;
        end else begin
          state_d = last_slot ? ST_DONE : ST_READ;
        end
      end
      ST_SQ: begin
        if (sq_cnt_q == 2'd3) begin
          state_d = ST_LAST;
        end
      end
      ST_LAST: state_d = ST_CMP;
      ST_CMP: begin
        state_d = (sts_i.hit || last_slot) ? ST_DONE : ST_READ;
      end
      ST_DONE: begin
        if (res_take_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Counters and the running answer
  always_comb begin
    idx_d    = idx_q;
    n_d      = n_q;
    sq_cnt_d = sq_cnt_q;
    vis_d    = vis_q;
    if (state_q == ST_IDLE && start_i) begin
      idx_d = '0;
      n_d   = n_clamp;
      vis_d = !invalid_i;
    end
    if (state_q == ST_ABS) begin
      sq_cnt_d = '0;
      if (sts_i.skip) begin
        idx_d = idx_nxt;
      end
    end
    if (state_q == ST_SQ) begin
      sq_cnt_d = sq_cnt_q + 1'b1;
    end
    if (state_q == ST_CMP) begin
      if (sts_i.hit) begin
        vis_d = 1'b0;
      end else begin
        idx_d = idx_nxt;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      idx_q    <= '0;
      n_q      <= '0;
      sq_cnt_q <= '0;
      vis_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      n_q      <= n_d;
      sq_cnt_q <= sq_cnt_d;
      vis_q    <= vis_d;
    end
  end

  // Outputs
  always_comb begin
    ctl_o          = '0;
    ctl_o.ld_point = (state_q == ST_IDLE) && start_i;
    ctl_o.ld_diff  = (state_q == ST_DIFF);
    ctl_o.ld_abs   = (state_q == ST_ABS);
    ctl_o.sq_en    = (state_q == ST_SQ);
    ctl_o.sq_sel   = sq_cnt_q;
    idle_o         = (state_q == ST_IDLE);
    res_valid_o    = (state_q == ST_DONE);
    res_visible_o  = vis_q;
    rd_en_o        = (state_q == ST_READ);
    rd_addr_o      = idx_q[AddrW-1:0];
  end

  `PISV_ASSERT_SAME(a_idx_in_range,
    (state_q == ST_READ || state_q == ST_DIFF || state_q == ST_ABS ||
     state_q == ST_SQ || state_q == ST_LAST || state_q == ST_CMP), idx_q < n_q)
  `PISV_ASSERT_NEXT(a_sq_to_last, (state_q == ST_SQ) && (sq_cnt_q == 2'd3),
    state_q == ST_LAST)
  `PISV_ASSERT_NEXT(a_hit_hides, (state_q == ST_CMP) && sts_i.hit,
    (state_q == ST_DONE) && !vis_q)
  `PISV_ASSERT_NEXT(a_invalid_hides, (state_q == ST_IDLE) && start_i && invalid_i,
    (state_q == ST_DONE) && !vis_q)

endmodule
